/* src/hcpf_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcpf_pkg
// Shared types, constants and datapath command codes of the harmonic cut
// pair force engine.
// ----------------------------------------------------------------------------
package hcpf_pkg;

  localparam int NUM_ATOMS_DEF = 1024;
  localparam int IDX_W         = 10;
  localparam int POS_W         = 32;
  localparam int FRC_W         = 48;
  localparam int CFG_W         = 31;
  localparam int CFG_IDX_W     = 1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_CUTOFF = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_SPRING = 1'b1;
  localparam logic [CFG_W-1:0]     CFG_ONE    = 31'd65536;

  // item operations
  localparam logic [1:0] OP_PAIR  = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  // coincident atoms: 0.001 in Q16.16 on each axis and its distance
  localparam logic [30:0] NUDGE   = 31'd66;
  localparam logic [30:0] NUDGE_R = 31'd114;

  // datapath command codes
  typedef logic [4:0] dp_code_t;
  localparam dp_code_t CMD_NOP       = 5'd0;
  localparam dp_code_t CMD_LOAD      = 5'd1;
  localparam dp_code_t CMD_CLEAR     = 5'd2;
  localparam dp_code_t CMD_SQ        = 5'd3;
  localparam dp_code_t CMD_SQ_ACC    = 5'd4;
  localparam dp_code_t CMD_CUTSQ     = 5'd5;
  localparam dp_code_t CMD_CMP       = 5'd6;
  localparam dp_code_t CMD_NUDGE     = 5'd7;
  localparam dp_code_t CMD_SQRT_INIT = 5'd8;
  localparam dp_code_t CMD_SQRT_STEP = 5'd9;
  localparam dp_code_t CMD_DIFF      = 5'd10;
  localparam dp_code_t CMD_KD        = 5'd11;
  localparam dp_code_t CMD_KD_ST     = 5'd12;
  localparam dp_code_t CMD_MUL_LO    = 5'd13;
  localparam dp_code_t CMD_ST_LO     = 5'd14;
  localparam dp_code_t CMD_MUL_HI    = 5'd15;
  localparam dp_code_t CMD_ST_HI     = 5'd16;
  localparam dp_code_t CMD_DIV_INIT  = 5'd17;
  localparam dp_code_t CMD_DIV_STEP  = 5'd18;
  localparam dp_code_t CMD_F_ST      = 5'd19;
  localparam dp_code_t CMD_RD_A      = 5'd20;
  localparam dp_code_t CMD_WR_A      = 5'd21;
  localparam dp_code_t CMD_RD_B      = 5'd22;
  localparam dp_code_t CMD_WR_B      = 5'd23;
  localparam dp_code_t CMD_OUT_PAIR  = 5'd24;
  localparam dp_code_t CMD_OUT_READ  = 5'd25;
  localparam dp_code_t CMD_OUT_ZERO  = 5'd26;

  typedef struct packed {
    logic [1:0]              op;
    logic [IDX_W-1:0]        index_a;
    logic [IDX_W-1:0]        index_b;
    logic signed [POS_W-1:0] pos_a_x;
    logic signed [POS_W-1:0] pos_a_y;
    logic signed [POS_W-1:0] pos_a_z;
    logic signed [POS_W-1:0] pos_b_x;
    logic signed [POS_W-1:0] pos_b_y;
    logic signed [POS_W-1:0] pos_b_z;
  } req_t;

  typedef struct packed {
    logic signed [FRC_W-1:0] force_x;
    logic signed [FRC_W-1:0] force_y;
    logic signed [FRC_W-1:0] force_z;
    logic                    in_range;
    logic                    saturated;
  } rsp_t;

  typedef struct packed {
    dp_code_t code;
  } dp_cmd_t;

  typedef struct packed {
    logic [1:0] op;
    logic       box;
    logic       near;
    logic       zero;
    logic       iter_last;
    logic       axis_last;
    logic       clr_last;
  } dp_status_t;

endpackage

/* src/hcpf_stream_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcpf_stream_if
// Valid/ready channel carrying one payload per transaction.
// ----------------------------------------------------------------------------
interface hcpf_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

/* src/harmonic_cut_pair_force_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// harmonic_cut_pair_force_core
// Harmonic cut pair force engine: pair forces with saturating per-atom
// accumulation, plus read and read-and-clear of one atom's force.
// ----------------------------------------------------------------------------
//  channel  dir  handshake          payload
//  req      in   valid/ready        hcpf_pkg::req_t (op, indices, positions)
//  rsp      out  valid/ready        hcpf_pkg::rsp_t (forces, in_range, saturated)
//  cfg      in   cfg_we only        cfg_index, cfg_data (cutoff, spring)
//
//  Pair in range: the result is set by the one-bit-per-cycle divider (46
//  steps per axis) and the square root (31 steps), which coincident atoms
//  skip. Out-of-range pairs and read/clear items take shorter paths. The
//  next item can be taken in the cycle after the result is loaded.
//  After reset a clearing pass over all NUM_ATOMS entries zeroes the
//  accumulators; no transaction is accepted meanwhile. One item is worked on
//  at a time; a stalled result holds in the output register while the next item is taken.
// ----------------------------------------------------------------------------
module harmonic_cut_pair_force_core #(
  parameter int NUM_ATOMS = hcpf_pkg::NUM_ATOMS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  hcpf_stream_if.sink                    req,
  hcpf_stream_if.source                  rsp,
  input  logic                           cfg_we,
  input  logic [hcpf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [hcpf_pkg::CFG_W-1:0]     cfg_data
);

  hcpf_pkg::dp_cmd_t    cmd;
  hcpf_pkg::dp_status_t status;
  hcpf_pkg::rsp_t       result;

  assign rsp.payload = result;

  hcpf_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .cmd       (cmd),
    .status    (status)
  );

  hcpf_datapath #(
    .NUM_ATOMS (NUM_ATOMS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .item      (req.payload),
    .result    (result),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

endmodule

/* src/hcpf_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcpf_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module hcpf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* src/hcpf_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcpf_datapath
// Displacement, shared 31x31 multiplier, bit-serial square root and divider,
// force accumulator memory and result register.
// ----------------------------------------------------------------------------
module hcpf_datapath #(
  parameter int NUM_ATOMS = hcpf_pkg::NUM_ATOMS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  hcpf_pkg::dp_cmd_t               cmd,
  output hcpf_pkg::dp_status_t            status,
  input  hcpf_pkg::req_t                  item,
  output hcpf_pkg::rsp_t                  result,
  input  logic                            cfg_we,
  input  logic [hcpf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [hcpf_pkg::CFG_W-1:0]      cfg_data
);

  localparam int AW  = $clog2(NUM_ATOMS);
  localparam int FW  = hcpf_pkg::FRC_W;
  localparam int MW  = 3 * FW;

  // saturating 48-bit add, flag in the top bit
  function automatic logic [FW:0] sat_add(input logic [FW-1:0] acc,
                                          input logic [FW-1:0] v);
    logic [FW:0] s;
    s = {acc[FW-1], acc} + {v[FW-1], v};
    if (s[FW] != s[FW-1]) begin
      sat_add = s[FW] ? {1'b1, 1'b1, {(FW-1){1'b0}}} : {1'b1, 1'b0, {(FW-1){1'b1}}};
    end else begin
      sat_add = {1'b0, s[FW-1:0]};
    end
  endfunction

  // configuration
  logic [30:0]   cut;
  logic [30:0]   k;
  logic [AW-1:0] clr_addr;

  // item state
  logic [1:0]               op_q;
  logic [9:0]               ia;
  logic [9:0]               ib;
  logic                     a_ok;
  logic                     b_ok;
  logic [30:0]              ad [3];
  logic                     dneg [3];
  logic                     box;
  logic                     near;
  logic                     zero;
  logic [63:0]              r2;
  logic [61:0]              prod;
  logic [32:0]              rem;
  logic [30:0]              root;
  logic [30:0]              adiff;
  logic                     dfneg;
  logic [61:0]              s;
  logic [92:0]              num;
  logic [46:0]              drem;
  logic [5:0]               iter;
  logic [1:0]               axis;
  logic [FW-1:0]            f [3];
  logic                     sat;

  // combinational helpers
  logic signed [32:0] dd [3];
  logic [32:0]        dabs [3];
  logic               box_c;
  logic [30:0]        ma;
  logic [30:0]        mb;
  logic [61:0]        mul_p;
  logic [34:0]        st;
  logic [34:0]        trial;
  logic [47:0]        dt;
  logic [47:0]        den;
  logic [31:0]        diffv;
  logic [FW-1:0]      mag;
  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  logic [MW-1:0]      ram_wdata;
  logic               ram_re;
  logic [AW-1:0]      ram_raddr;
  logic [MW-1:0]      ram_rdata;
  logic [FW-1:0]      cur [3];
  logic [FW:0]        upd [3];
  logic               upd_hit;
  logic               upd_sat;
  logic signed [31:0] pa [3];
  logic signed [31:0] pb [3];

  // displacement and bounding box test of the incoming pair
  assign pa[0] = item.pos_a_x;
  assign pa[1] = item.pos_a_y;
  assign pa[2] = item.pos_a_z;
  assign pb[0] = item.pos_b_x;
  assign pb[1] = item.pos_b_y;
  assign pb[2] = item.pos_b_z;

  always_comb begin
    box_c = 1'b1;
    for (int j = 0; j < 3; j++) begin
      dd[j]   = {pa[j][31], pa[j]} - {pb[j][31], pb[j]};
      dabs[j] = dd[j][32] ? 33'(-dd[j]) : 33'(dd[j]);
      if (dabs[j] >= {2'b00, cut}) begin
        box_c = 1'b0;
      end
    end
  end

  // shared multiplier operand select
  always_comb begin
    ma = '0;
    mb = '0;
    unique case (cmd.code)
      hcpf_pkg::CMD_SQ: begin
        ma = ad[axis];
        mb = ad[axis];
      end
      hcpf_pkg::CMD_CUTSQ: begin
        ma = cut;
        mb = cut;
      end
      hcpf_pkg::CMD_KD: begin
        ma = k;
        mb = adiff;
      end
      hcpf_pkg::CMD_MUL_LO: begin
        ma = s[30:0];
        mb = ad[axis];
      end
      hcpf_pkg::CMD_MUL_HI: begin
        ma = s[61:31];
        mb = ad[axis];
      end
      default: begin
      end
    endcase
  end

  assign mul_p = 62'(ma) * 62'(mb);

  // square root and divider step terms
  assign st    = {rem, r2[61:60]};
  assign trial = {2'b00, root, 2'b01};
  assign dt    = {drem, num[45]};
  assign den   = {1'b0, root, 16'h0000};
  assign diffv = {1'b0, cut} - {1'b0, root};
  assign mag   = {2'b00, num[45:0]};

  // accumulator read-modify-write
  assign cur[0] = ram_rdata[MW-1 -: FW];
  assign cur[1] = ram_rdata[FW +: FW];
  assign cur[2] = ram_rdata[FW-1:0];

  always_comb begin
    upd_sat = 1'b0;
    for (int j = 0; j < 3; j++) begin
      upd[j]  = sat_add(cur[j], (cmd.code == hcpf_pkg::CMD_WR_B) ? -f[j] : f[j]);
      upd_sat = upd_sat | upd[j][FW];
    end
  end

  assign upd_hit = ((cmd.code == hcpf_pkg::CMD_WR_A) && a_ok) ||
                   ((cmd.code == hcpf_pkg::CMD_WR_B) && b_ok);

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = AW'(ia);
    ram_wdata = '0;
    unique case (cmd.code)
      hcpf_pkg::CMD_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_addr;
      end
      hcpf_pkg::CMD_WR_A: begin
        ram_we    = a_ok;
        ram_wdata = {upd[0][FW-1:0], upd[1][FW-1:0], upd[2][FW-1:0]};
      end
      hcpf_pkg::CMD_WR_B: begin
        ram_we    = b_ok;
        ram_waddr = AW'(ib);
        ram_wdata = {upd[0][FW-1:0], upd[1][FW-1:0], upd[2][FW-1:0]};
      end
      hcpf_pkg::CMD_OUT_READ: begin
        ram_we = a_ok && (op_q == hcpf_pkg::OP_CLEAR);
      end
      default: begin
      end
    endcase
  end

  assign ram_re    = (cmd.code == hcpf_pkg::CMD_RD_A) || (cmd.code == hcpf_pkg::CMD_RD_B);
  assign ram_raddr = (cmd.code == hcpf_pkg::CMD_RD_B) ? AW'(ib) : AW'(ia);

  hcpf_ram #(
    .WIDTH (MW),
    .DEPTH (NUM_ATOMS)
  ) u_accum (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // configuration registers and clearing pass address
  always_ff @(posedge clk) begin
    if (rst) begin
      cut      <= hcpf_pkg::CFG_ONE;
      k        <= hcpf_pkg::CFG_ONE;
      clr_addr <= '0;
    end else begin
      if (cmd.code == hcpf_pkg::CMD_CLEAR) begin
        clr_addr <= clr_addr + 1'b1;
      end
      if (cfg_we) begin
        unique case (cfg_index)
          hcpf_pkg::REG_CUTOFF: cut <= cfg_data;
          hcpf_pkg::REG_SPRING: k   <= cfg_data;
          default: begin
          end
        endcase
      end
    end
  end

  // working registers, advanced by the controller's command
  always_ff @(posedge clk) begin
    unique case (cmd.code)
      hcpf_pkg::CMD_LOAD: begin
        op_q <= item.op;
        ia   <= item.index_a;
        ib   <= item.index_b;
        a_ok <= 32'(item.index_a) < 32'(NUM_ATOMS);
        b_ok <= 32'(item.index_b) < 32'(NUM_ATOMS);
        for (int j = 0; j < 3; j++) begin
          ad[j]   <= dabs[j][30:0];
          dneg[j] <= dd[j][32];
        end
        box  <= box_c;
        r2   <= '0;
        axis <= '0;
        sat  <= 1'b0;
      end
      hcpf_pkg::CMD_SQ, hcpf_pkg::CMD_CUTSQ, hcpf_pkg::CMD_KD,
      hcpf_pkg::CMD_MUL_LO, hcpf_pkg::CMD_MUL_HI: begin
        prod <= mul_p;
      end
      hcpf_pkg::CMD_SQ_ACC: begin
        r2   <= r2 + 64'(prod);
        axis <= (axis == 2'd2) ? 2'd0 : axis + 2'd1;
      end
      hcpf_pkg::CMD_CMP: begin
        near <= r2 < {2'b00, prod};
        zero <= r2 == '0;
      end
      hcpf_pkg::CMD_NUDGE: begin
        for (int j = 0; j < 3; j++) begin
          ad[j]   <= hcpf_pkg::NUDGE;
          dneg[j] <= 1'b0;
        end
        root <= hcpf_pkg::NUDGE_R;
      end
      hcpf_pkg::CMD_SQRT_INIT: begin
        rem  <= '0;
        root <= '0;
        iter <= 6'd30;
      end
      hcpf_pkg::CMD_SQRT_STEP: begin
        if (st >= trial) begin
          rem  <= 33'(st - trial);
          root <= {root[29:0], 1'b1};
        end else begin
          rem  <= st[32:0];
          root <= {root[29:0], 1'b0};
        end
        r2   <= {r2[61:0], 2'b00};
        iter <= iter - 6'd1;
      end
      hcpf_pkg::CMD_DIFF: begin
        dfneg <= diffv[31];
        adiff <= diffv[31] ? 31'(-diffv) : diffv[30:0];
      end
      hcpf_pkg::CMD_KD_ST: begin
        s <= prod;
      end
      hcpf_pkg::CMD_ST_LO: begin
        num <= 93'(prod);
      end
      hcpf_pkg::CMD_ST_HI: begin
        num <= num + {prod, 31'h0};
      end
      hcpf_pkg::CMD_DIV_INIT: begin
        drem <= num[92:46];
        iter <= 6'd45;
      end
      hcpf_pkg::CMD_DIV_STEP: begin
        if (dt >= den) begin
          drem       <= 47'(dt - den);
          num[45:0]  <= {num[44:0], 1'b1};
        end else begin
          drem       <= dt[46:0];
          num[45:0]  <= {num[44:0], 1'b0};
        end
        iter <= iter - 6'd1;
      end
      hcpf_pkg::CMD_F_ST: begin
        f[axis] <= (dneg[axis] ^ dfneg) ? -mag : mag;
        axis    <= (axis == 2'd2) ? 2'd0 : axis + 2'd1;
      end
      hcpf_pkg::CMD_WR_A, hcpf_pkg::CMD_WR_B: begin
        if (upd_hit) begin
          sat <= sat | upd_sat;
        end
      end
      hcpf_pkg::CMD_OUT_PAIR: begin
        result.force_x   <= f[0];
        result.force_y   <= f[1];
        result.force_z   <= f[2];
        result.in_range  <= 1'b1;
        result.saturated <= sat;
      end
      hcpf_pkg::CMD_OUT_READ: begin
        result.force_x   <= a_ok ? cur[0] : '0;
        result.force_y   <= a_ok ? cur[1] : '0;
        result.force_z   <= a_ok ? cur[2] : '0;
        result.in_range  <= 1'b0;
        result.saturated <= 1'b0;
      end
      hcpf_pkg::CMD_OUT_ZERO: begin
        result <= '0;
      end
      default: begin
      end
    endcase
  end

  // status to the controller
  assign status.op        = op_q;
  assign status.box       = box;
  assign status.near      = near;
  assign status.zero      = zero;
  assign status.iter_last = iter == '0;
  assign status.axis_last = axis == 2'd2;
  assign status.clr_last  = clr_addr == AW'(NUM_ATOMS - 1);

endmodule

/* src/hcpf_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcpf_ctrl
// Sequencer: clearing pass, item acceptance, step order of the pair force
// computation and the result handshake.
// ----------------------------------------------------------------------------
module hcpf_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 req_valid,
  output logic                 req_ready,
  output logic                 rsp_valid,
  input  logic                 rsp_ready,
  output hcpf_pkg::dp_cmd_t    cmd,
  input  hcpf_pkg::dp_status_t status
);

  localparam logic [4:0] S_CLEAR     = 5'd0;
  localparam logic [4:0] S_IDLE      = 5'd1;
  localparam logic [4:0] S_DECIDE    = 5'd2;
  localparam logic [4:0] S_SQ        = 5'd3;
  localparam logic [4:0] S_SQ_ACC    = 5'd4;
  localparam logic [4:0] S_CUTSQ     = 5'd5;
  localparam logic [4:0] S_CMP       = 5'd6;
  localparam logic [4:0] S_ROUTE     = 5'd7;
  localparam logic [4:0] S_NUDGE     = 5'd8;
  localparam logic [4:0] S_SQRT_INIT = 5'd9;
  localparam logic [4:0] S_SQRT      = 5'd10;
  localparam logic [4:0] S_DIFF      = 5'd11;
  localparam logic [4:0] S_KD        = 5'd12;
  localparam logic [4:0] S_KD_ST     = 5'd13;
  localparam logic [4:0] S_MUL_LO    = 5'd14;
  localparam logic [4:0] S_ST_LO     = 5'd15;
  localparam logic [4:0] S_MUL_HI    = 5'd16;
  localparam logic [4:0] S_ST_HI     = 5'd17;
  localparam logic [4:0] S_DIV_INIT  = 5'd18;
  localparam logic [4:0] S_DIV       = 5'd19;
  localparam logic [4:0] S_F_ST      = 5'd20;
  localparam logic [4:0] S_RD_A      = 5'd21;
  localparam logic [4:0] S_WR_A      = 5'd22;
  localparam logic [4:0] S_RD_B      = 5'd23;
  localparam logic [4:0] S_WR_B      = 5'd24;
  localparam logic [4:0] S_RD_Q      = 5'd25;
  localparam logic [4:0] S_OUT_PAIR  = 5'd26;
  localparam logic [4:0] S_OUT_READ  = 5'd27;
  localparam logic [4:0] S_OUT_ZERO  = 5'd28;

  logic [4:0] state;
  logic [4:0] state_next;
  logic       out_valid;
  logic       out_valid_next;
  logic       slot_free;

  assign slot_free = !out_valid || rsp_ready;
  assign req_ready = state == S_IDLE;
  assign rsp_valid = out_valid;

  // next state and command
  always_comb begin
    state_next     = state;
    cmd.code       = hcpf_pkg::CMD_NOP;
    out_valid_next = out_valid && !rsp_ready;
    unique case (state)
      S_CLEAR: begin
        cmd.code = hcpf_pkg::CMD_CLEAR;
        if (status.clr_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (req_valid) begin
          cmd.code   = hcpf_pkg::CMD_LOAD;
          state_next = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (status.op == hcpf_pkg::OP_PAIR) begin
          state_next = status.box ? S_SQ : S_OUT_ZERO;
        end else if (status.op == hcpf_pkg::OP_READ || status.op == hcpf_pkg::OP_CLEAR) begin
          state_next = S_RD_Q;
        end else begin
          state_next = S_OUT_ZERO;
        end
      end
      S_SQ: begin
        cmd.code   = hcpf_pkg::CMD_SQ;
        state_next = S_SQ_ACC;
      end
      S_SQ_ACC: begin
        cmd.code   = hcpf_pkg::CMD_SQ_ACC;
        state_next = status.axis_last ? S_CUTSQ : S_SQ;
      end
      S_CUTSQ: begin
        cmd.code   = hcpf_pkg::CMD_CUTSQ;
        state_next = S_CMP;
      end
      S_CMP: begin
        cmd.code   = hcpf_pkg::CMD_CMP;
        state_next = S_ROUTE;
      end
      S_ROUTE: begin
        if (!status.near) begin
          state_next = S_OUT_ZERO;
        end else begin
          state_next = status.zero ? S_NUDGE : S_SQRT_INIT;
        end
      end
      S_NUDGE: begin
        cmd.code   = hcpf_pkg::CMD_NUDGE;
        state_next = S_DIFF;
      end
      S_SQRT_INIT: begin
        cmd.code   = hcpf_pkg::CMD_SQRT_INIT;
        state_next = S_SQRT;
      end
      S_SQRT: begin
        cmd.code = hcpf_pkg::CMD_SQRT_STEP;
        if (status.iter_last) begin
          state_next = S_DIFF;
        end
      end
      S_DIFF: begin
        cmd.code   = hcpf_pkg::CMD_DIFF;
        state_next = S_KD;
      end
      S_KD: begin
        cmd.code   = hcpf_pkg::CMD_KD;
        state_next = S_KD_ST;
      end
      S_KD_ST: begin
        cmd.code   = hcpf_pkg::CMD_KD_ST;
        state_next = S_MUL_LO;
      end
      S_MUL_LO: begin
        cmd.code   = hcpf_pkg::CMD_MUL_LO;
        state_next = S_ST_LO;
      end
      S_ST_LO: begin
        cmd.code   = hcpf_pkg::CMD_ST_LO;
        state_next = S_MUL_HI;
      end
      S_MUL_HI: begin
        cmd.code   = hcpf_pkg::CMD_MUL_HI;
        state_next = S_ST_HI;
      end
      S_ST_HI: begin
        cmd.code   = hcpf_pkg::CMD_ST_HI;
        state_next = S_DIV_INIT;
      end
      S_DIV_INIT: begin
        cmd.code   = hcpf_pkg::CMD_DIV_INIT;
        state_next = S_DIV;
      end
      S_DIV: begin
        cmd.code = hcpf_pkg::CMD_DIV_STEP;
        if (status.iter_last) begin
          state_next = S_F_ST;
        end
      end
      S_F_ST: begin
        cmd.code   = hcpf_pkg::CMD_F_ST;
        state_next = status.axis_last ? S_RD_A : S_MUL_LO;
      end
      S_RD_A: begin
        cmd.code   = hcpf_pkg::CMD_RD_A;
        state_next = S_WR_A;
      end
      S_WR_A: begin
        cmd.code   = hcpf_pkg::CMD_WR_A;
        state_next = S_RD_B;
      end
      S_RD_B: begin
        cmd.code   = hcpf_pkg::CMD_RD_B;
        state_next = S_WR_B;
      end
      S_WR_B: begin
        cmd.code   = hcpf_pkg::CMD_WR_B;
        state_next = S_OUT_PAIR;
      end
      S_RD_Q: begin
        cmd.code   = hcpf_pkg::CMD_RD_A;
        state_next = S_OUT_READ;
      end
      S_OUT_PAIR: begin
        if (slot_free) begin
          cmd.code       = hcpf_pkg::CMD_OUT_PAIR;
          out_valid_next = 1'b1;
          state_next     = S_IDLE;
        end
      end
      S_OUT_READ: begin
        if (slot_free) begin
          cmd.code       = hcpf_pkg::CMD_OUT_READ;
          out_valid_next = 1'b1;
          state_next     = S_IDLE;
        end
      end
      S_OUT_ZERO: begin
        if (slot_free) begin
          cmd.code       = hcpf_pkg::CMD_OUT_ZERO;
          out_valid_next = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // state and result valid registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

/* src/hcpf_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcpf_checker
// Port-level checks of the pair force engine, bound to the top level.
// ----------------------------------------------------------------------------
module hcpf_checker (
  input logic           clk,
  input logic           rst,
  input logic           req_valid,
  input logic           req_ready,
  input logic           rsp_valid,
  input logic           rsp_ready,
  input hcpf_pkg::rsp_t rsp_payload
);

  // hold a stalled result
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid)
    else $error("result dropped while stalled");

  a_rsp_stable: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> $stable(rsp_payload))
    else $error("stalled result changed");

  // saturation is only reported for an in-range pair
  a_sat_in_range: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (rsp_payload.in_range || !rsp_payload.saturated))
    else $error("saturated without in_range");

  // one item at a time: ready drops after each transaction
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("second item accepted back to back");

endmodule

bind harmonic_cut_pair_force_core hcpf_checker u_hcpf_checker (
  .clk         (clk),
  .rst         (rst),
  .req_valid   (req.valid),
  .req_ready   (req.ready),
  .rsp_valid   (rsp.valid),
  .rsp_ready   (rsp.ready),
  .rsp_payload (rsp.payload)
);
